// File: src/vcdg_pkg.sv
// vcdg_pkg: shared types and constants of the central-difference gradient block
// no dependencies; imported by every module under src

package vcdg_pkg;

    // sample and result widths
    localparam int SAMPLE_W   = 16;
    localparam int GRAD_W     = 17;
    localparam int CFG_W      = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 56;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_Z = 2'd2;

    // reset value of each size register
    localparam logic [CFG_W-1:0] SIZE_RESET = 9'd64;

    // item kinds carried on tuser
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // one plane-store entry: same in-plane position in the two latest planes
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] older;
        logic signed [SAMPLE_W-1:0] newer;
    } vcdg_pair_t;

    // scan status from the controller to the stencil datapath
    typedef struct packed {
        logic x_first;
        logic x_last;
        logic y_first;
        logic y_last;
        logic z_first;
        logic vol_last;
        logic cur_take_a;
        logic cur_take_w;
    } vcdg_scan_t;

endpackage

// File: src/vcdg_plane_mem.sv
// vcdg_plane_mem: plane store, one write port and two registered read ports
// same-cycle write to a read address is forwarded; uses vcdg_pkg

module vcdg_plane_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  vcdg_pkg::vcdg_pair_t  wdata,
    input  logic [AW-1:0]         raddr_a,
    input  logic [AW-1:0]         raddr_b,
    output vcdg_pkg::vcdg_pair_t  rdata_a,
    output vcdg_pkg::vcdg_pair_t  rdata_b
);
    import vcdg_pkg::*;

    vcdg_pair_t pair_mem [DEPTH];
    vcdg_pair_t rd_a_reg;
    vcdg_pair_t rd_b_reg;
    vcdg_pair_t wdata_reg;
    logic       fwd_a_reg;
    logic       fwd_b_reg;

    // storage array and read registers
    always_ff @(posedge aclk) begin
        if (we) begin
            pair_mem[waddr] <= wdata;
        end
        rd_a_reg  <= pair_mem[raddr_a];
        rd_b_reg  <= pair_mem[raddr_b];
        wdata_reg <= wdata;
    end

    // write-to-read collision flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end else begin
            fwd_a_reg <= we && (raddr_a == waddr);
            fwd_b_reg <= we && (raddr_b == waddr);
        end
    end

    assign rdata_a = fwd_a_reg ? wdata_reg : rd_a_reg;
    assign rdata_b = fwd_b_reg ? wdata_reg : rd_b_reg;

endmodule

// File: src/vcdg_row_mem.sv
// vcdg_row_mem: row store of emitted center samples, indexed by x position
// one write and one registered read port with forwarding; uses vcdg_pkg

module vcdg_row_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  we,
    input  logic [AW-1:0]                         waddr,
    input  logic signed [vcdg_pkg::SAMPLE_W-1:0]  wdata,
    input  logic [AW-1:0]                         raddr,
    output logic signed [vcdg_pkg::SAMPLE_W-1:0]  rdata
);
    import vcdg_pkg::*;

    logic signed [SAMPLE_W-1:0] row_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_reg;
    logic signed [SAMPLE_W-1:0] wdata_reg;
    logic                       fwd_reg;

    // storage array and read register
    always_ff @(posedge aclk) begin
        if (we) begin
            row_mem[waddr] <= wdata;
        end
        rd_reg    <= row_mem[raddr];
        wdata_reg <= wdata;
    end

    // write-to-read collision flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= we && (raddr == waddr);
        end
    end

    assign rdata = fwd_reg ? wdata_reg : rd_reg;

endmodule

// File: src/vcdg_scan_ctrl.sv
// vcdg_scan_ctrl: input and output scan counters, drain flag, store addresses
// read addresses come from next-state counters so read data matches the
// current voxel; uses vcdg_pkg

module vcdg_scan_ctrl #(
    parameter int CW_X = 8,
    parameter int CW_Y = 8,
    parameter int CW_Z = 8,
    parameter int AW   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 restart,
    input  logic                 item_fire,
    input  logic                 item_flush,
    input  logic [CW_X-1:0]      x_max,
    input  logic [CW_Y-1:0]      y_max,
    input  logic [CW_Z-1:0]      z_max,
    input  logic [AW-1:0]        row_len,
    output logic                 emit,
    output logic                 samp_we,
    output logic [AW-1:0]        samp_waddr,
    output logic [AW-1:0]        rd_addr_a,
    output logic [AW-1:0]        rd_addr_b,
    output logic [CW_X-1:0]      row_waddr,
    output logic [CW_X-1:0]      row_raddr,
    output vcdg_pkg::vcdg_scan_t scan
);
    import vcdg_pkg::*;

    logic [CW_X-1:0] xi_in_reg, xi_in_next, xi_out_reg, xi_out_next;
    logic [CW_Y-1:0] yi_in_reg, yi_in_next, yi_out_reg, yi_out_next;
    logic [CW_Z-1:0] zi_in_reg, zi_in_next, zi_out_reg, zi_out_next;
    logic [AW-1:0]   q_in_reg, q_in_next, q_out_reg, q_out_next;
    logic            draining_reg, draining_next;

    logic take_sample;
    logic take_flush;
    logic in_x_end, in_y_end, in_end;
    logic out_x_end, out_y_end, out_end;
    logic next_plane_end;

    // decode the transfer and the scan position
    always_comb begin
        take_sample = item_fire && (item_flush == KIND_SAMPLE) && !draining_reg;
        take_flush  = item_fire && (item_flush == KIND_FLUSH) && draining_reg;
        in_x_end    = (xi_in_reg == x_max);
        in_y_end    = (yi_in_reg == y_max);
        in_end      = in_x_end && in_y_end && (zi_in_reg == z_max);
        out_x_end   = (xi_out_reg == x_max);
        out_y_end   = (yi_out_reg == y_max);
        out_end     = out_x_end && out_y_end && (zi_out_reg == z_max);
        emit        = (take_sample && (zi_in_reg != '0)) || take_flush;
    end

    // counter next state
    always_comb begin
        xi_in_next    = xi_in_reg;
        yi_in_next    = yi_in_reg;
        zi_in_next    = zi_in_reg;
        q_in_next     = q_in_reg;
        xi_out_next   = xi_out_reg;
        yi_out_next   = yi_out_reg;
        zi_out_next   = zi_out_reg;
        q_out_next    = q_out_reg;
        draining_next = draining_reg;
        if (restart || (take_flush && out_end)) begin
            xi_in_next    = '0;
            yi_in_next    = '0;
            zi_in_next    = '0;
            q_in_next     = '0;
            xi_out_next   = '0;
            yi_out_next   = '0;
            zi_out_next   = '0;
            q_out_next    = '0;
            draining_next = 1'b0;
        end else begin
            // input side: last sample of the volume starts the drain
            if (take_sample) begin
                if (in_end) begin
                    draining_next = 1'b1;
                end else if (in_x_end) begin
                    xi_in_next = '0;
                    if (in_y_end) begin
                        yi_in_next = '0;
                        q_in_next  = '0;
                        zi_in_next = zi_in_reg + CW_Z'(1);
                    end else begin
                        yi_in_next = yi_in_reg + CW_Y'(1);
                        q_in_next  = q_in_reg + AW'(1);
                    end
                end else begin
                    xi_in_next = xi_in_reg + CW_X'(1);
                    q_in_next  = q_in_reg + AW'(1);
                end
            end
            // output side
            if (emit) begin
                if (out_x_end) begin
                    xi_out_next = '0;
                    if (out_y_end) begin
                        yi_out_next = '0;
                        q_out_next  = '0;
                        zi_out_next = zi_out_reg + CW_Z'(1);
                    end else begin
                        yi_out_next = yi_out_reg + CW_Y'(1);
                        q_out_next  = q_out_reg + AW'(1);
                    end
                end else begin
                    xi_out_next = xi_out_reg + CW_X'(1);
                    q_out_next  = q_out_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xi_in_reg    <= '0;
            yi_in_reg    <= '0;
            zi_in_reg    <= '0;
            q_in_reg     <= '0;
            xi_out_reg   <= '0;
            yi_out_reg   <= '0;
            zi_out_reg   <= '0;
            q_out_reg    <= '0;
            draining_reg <= 1'b0;
        end else begin
            xi_in_reg    <= xi_in_next;
            yi_in_reg    <= yi_in_next;
            zi_in_reg    <= zi_in_next;
            q_in_reg     <= q_in_next;
            xi_out_reg   <= xi_out_next;
            yi_out_reg   <= yi_out_next;
            zi_out_reg   <= zi_out_next;
            q_out_reg    <= q_out_next;
            draining_reg <= draining_next;
        end
    end

    // store addresses: next voxel and the row below the next output voxel
    always_comb begin
        next_plane_end = (xi_out_next == x_max) && (yi_out_next == y_max);
        rd_addr_a      = next_plane_end ? '0 : q_out_next + AW'(1);
        rd_addr_b      = q_out_next + row_len;
        row_raddr      = xi_out_next;
        row_waddr      = xi_out_reg;
        samp_we        = take_sample;
        samp_waddr     = q_in_reg;
    end

    // status toward the stencil datapath
    always_comb begin
        scan.x_first    = (xi_out_reg == '0);
        scan.x_last     = out_x_end;
        scan.y_first    = (yi_out_reg == '0);
        scan.y_last     = out_y_end;
        scan.z_first    = (zi_out_reg == '0);
        scan.vol_last   = out_end;
        scan.cur_take_a = emit;
        // a one-voxel plane or the first sample lands on the center entry
        scan.cur_take_w = take_sample &&
                          (emit ? ((x_max == '0) && (y_max == '0))
                                : (q_in_reg == q_out_reg));
    end

endmodule

// File: src/volume_central_difference_gradient.sv
// Central-difference gradient of a raster-order 3-D volume, clamped borders.
//
// Input stream: s_axis_tdata holds one signed 16-bit sample, s_axis_tuser the
// item kind (0 = sample, 1 = flush). Output stream: m_axis_tdata holds twice
// the x, y and z gradient as signed 17-bit values, m_axis_tlast marks the
// final voxel of the volume. Sizes are set through cfg_we/cfg_addr/cfg_wdata;
// any size write restarts the volume.
// With P voxels per plane, the sample that completes voxel n + P releases the
// result of voxel n; after the last sample, each flush transfer releases one
// of the last plane's voxels. Samples during a drain and flushes outside one
// are taken and dropped.
// Throughput is one item per cycle unless the receiver stalls; a result is
// on the output register in the cycle after the transfer that releases it.
// Every cycle reads the plane store at two addresses, the row store at one; a
// taken sample writes the plane store and a released result the row store.
// Reset restores sizes of 64 and an empty volume; the stores need no clearing.
// While the receiver stalls with a result held, s_axis_tready stays low.
// Files: vcdg_pkg, vcdg_plane_mem, vcdg_row_mem, vcdg_scan_ctrl.

module volume_central_difference_gradient #(
    parameter int MAX_X = 256,
    parameter int MAX_Y = 256,
    parameter int MAX_Z = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [vcdg_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [15:0] sample
    input  logic                                 s_axis_tuser,  // [0] kind
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [16:0] grad_x, [33:17] grad_y, [50:34] grad_z, [55:51] zero
    output logic [vcdg_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,  // last
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [vcdg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [vcdg_pkg::CFG_W-1:0]           cfg_wdata
);
    import vcdg_pkg::*;

    localparam int CW_X     = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int CW_Y     = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int CW_Z     = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int PLANE_D  = MAX_X * MAX_Y;
    localparam int AW       = (PLANE_D > 1) ? $clog2(PLANE_D) : 1;
    localparam int PAD_W    = OUT_DATA_W - 3 * GRAD_W;

    logic [CFG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [CW_X-1:0]  x_max;
    logic [CW_Y-1:0]  y_max;
    logic [CW_Z-1:0]  z_max;
    logic [AW-1:0]    row_len;
    logic             restart;

    logic             item_fire;
    logic             emit;
    logic             samp_we;
    logic [AW-1:0]    samp_waddr;
    logic [AW-1:0]    rd_addr_a;
    logic [AW-1:0]    rd_addr_b;
    logic [CW_X-1:0]  row_waddr;
    logic [CW_X-1:0]  row_raddr;
    vcdg_scan_t       scan;

    vcdg_pair_t       samp_wdata;
    vcdg_pair_t       rd_a;
    vcdg_pair_t       rd_b;
    logic signed [SAMPLE_W-1:0] row_rd;
    logic signed [SAMPLE_W-1:0] sample;

    vcdg_pair_t                 cur_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;

    logic signed [SAMPLE_W-1:0] xp, xm, yp, ym, zp, zm, ctr;
    logic signed [GRAD_W-1:0]   grad_x_next, grad_y_next, grad_z_next;

    logic                       m_valid_reg;
    logic signed [GRAD_W-1:0]   grad_x_reg, grad_y_reg, grad_z_reg;
    logic                       last_reg;

    // configuration registers; a size write restarts the volume
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SIZE_X: size_x_reg <= cfg_wdata;
                CFG_SIZE_Y: size_y_reg <= cfg_wdata;
                CFG_SIZE_Z: size_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign restart = cfg_we && ((cfg_addr == CFG_SIZE_X) || (cfg_addr == CFG_SIZE_Y) ||
                                (cfg_addr == CFG_SIZE_Z));

    // effective sizes as last index, zero taken as one, capped at the maximum
    always_comb begin
        if (size_x_reg == '0) begin
            x_max = '0;
        end else if (32'(size_x_reg) > MAX_X) begin
            x_max = CW_X'(MAX_X - 1);
        end else begin
            x_max = CW_X'(size_x_reg - CFG_W'(1));
        end
        if (size_y_reg == '0) begin
            y_max = '0;
        end else if (32'(size_y_reg) > MAX_Y) begin
            y_max = CW_Y'(MAX_Y - 1);
        end else begin
            y_max = CW_Y'(size_y_reg - CFG_W'(1));
        end
        if (size_z_reg == '0) begin
            z_max = '0;
        end else if (32'(size_z_reg) > MAX_Z) begin
            z_max = CW_Z'(MAX_Z - 1);
        end else begin
            z_max = CW_Z'(size_z_reg - CFG_W'(1));
        end
        row_len = AW'(x_max) + AW'(1);
    end

    // input handshake: take an item whenever the output register can load
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign item_fire     = s_axis_tvalid && s_axis_tready;
    assign sample        = $signed(s_axis_tdata[SAMPLE_W-1:0]);

    vcdg_scan_ctrl #(
        .CW_X (CW_X),
        .CW_Y (CW_Y),
        .CW_Z (CW_Z),
        .AW   (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart),
        .item_fire  (item_fire),
        .item_flush (s_axis_tuser),
        .x_max      (x_max),
        .y_max      (y_max),
        .z_max      (z_max),
        .row_len    (row_len),
        .emit       (emit),
        .samp_we    (samp_we),
        .samp_waddr (samp_waddr),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .row_waddr  (row_waddr),
        .row_raddr  (row_raddr),
        .scan       (scan)
    );

    // new entry keeps the previous plane's sample at this position
    always_comb begin
        samp_wdata.older = cur_reg.newer;
        samp_wdata.newer = sample;
    end

    vcdg_plane_mem #(
        .DEPTH (PLANE_D),
        .AW    (AW)
    ) u_plane_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (samp_we),
        .waddr   (samp_waddr),
        .wdata   (samp_wdata),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    vcdg_row_mem #(
        .DEPTH (MAX_X),
        .AW    (CW_X)
    ) u_row_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (emit),
        .waddr   (row_waddr),
        .wdata   (cur_reg.newer),
        .raddr   (row_raddr),
        .rdata   (row_rd)
    );

    // center entry of the current output voxel and its left neighbor
    always_ff @(posedge aclk) begin
        if (scan.cur_take_w) begin
            cur_reg <= samp_wdata;
        end else if (scan.cur_take_a) begin
            cur_reg <= rd_a;
        end
        if (emit) begin
            prev_reg <= cur_reg.newer;
        end
    end

    // stencil: clamped neighbors and doubled gradients
    always_comb begin
        ctr = cur_reg.newer;
        xp  = scan.x_last  ? ctr : rd_a.newer;
        xm  = scan.x_first ? ctr : prev_reg;
        yp  = scan.y_last  ? ctr : rd_b.newer;
        ym  = scan.y_first ? ctr : row_rd;
        zp  = (s_axis_tuser == KIND_FLUSH) ? ctr : sample;
        zm  = scan.z_first ? ctr : cur_reg.older;
        grad_x_next = GRAD_W'(xp) - GRAD_W'(xm);
        grad_y_next = GRAD_W'(yp) - GRAD_W'(ym);
        grad_z_next = GRAD_W'(zp) - GRAD_W'(zm);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            grad_x_reg <= grad_x_next;
            grad_y_reg <= grad_y_next;
            grad_z_reg <= grad_z_next;
            last_reg   <= scan.vol_last && (s_axis_tuser == KIND_FLUSH);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, grad_z_reg, grad_y_reg, grad_x_reg};
    assign m_axis_tlast  = last_reg;

endmodule
